// ===== design/lvlp_pkg.sv =====
// lvlp_pkg: shared types, constants and helpers for the label/value line parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package lvlp_pkg;

  localparam int LABEL_MAX_DEF = 16;
  localparam int VALUE_MAX_DEF = 32;
  localparam int CNT_W         = 6;   // holds a count up to 32 (widest store allowed)
  localparam int TOT_W         = CNT_W + 1;
  localparam int GAP_W         = 16;
  localparam int TIME_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int END_WORD_LEN  = 8;

  localparam logic [GAP_W-1:0] GAP_RESET = 16'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUB_INTERVAL = 2'd1;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LABEL,
    PH_VALUE,
    PH_HEX
  } phase_t;

  typedef struct packed {
    logic [7:0]        rx_char;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] record_char;
    logic       char_valid;
    logic       in_value;
    logic       truncated;
    logic       last;
  } out_item_t;

  // record handed from parser to readout
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] label_count;
    logic [CNT_W-1:0] value_count;
    logic             overflow;
  } rec_t;

  // "Checksum"
  function automatic logic [7:0] end_word_char(input logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0: ch = 8'h43;
      3'd1: ch = 8'h68;
      3'd2: ch = 8'h65;
      3'd3: ch = 8'h63;
      3'd4: ch = 8'h6B;
      3'd5: ch = 8'h73;
      3'd6: ch = 8'h75;
      3'd7: ch = 8'h6D;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== design/label_value_line_parser.sv =====
// label_value_line_parser: top level of the label/value text line parser.
// Instantiates lvlp_parse, lvlp_mem and lvlp_emit; uses lvlp_pkg.
//
//   channel  handshake              payload      role
//   in_      in_valid / in_ready    in_item_t    received byte + ms timestamp
//   out_     out_valid / out_ready  out_item_t   published record bytes
//   cfg_     cfg_we                 cfg_index    register write, no wait
//
// A byte is parsed in the cycle it is accepted. A line end that publishes a
// record makes the block read its label_count + value_count entries (one
// empty item for an empty record) from the single-port-read store, one entry per
// cycle; in_ready is low meanwhile. out_ready low holds the read pipeline.
// Reset is synchronous and needs no clearing pass. Store writes and reads
// never overlap in time.
`default_nettype none
module label_value_line_parser #(
  parameter int LABEL_MAX = lvlp_pkg::LABEL_MAX_DEF,
  parameter int VALUE_MAX = lvlp_pkg::VALUE_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lvlp_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lvlp_pkg::out_item_t                  out_item,
  input  wire logic                            cfg_we,
  input  wire logic [lvlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lvlp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lvlp_pkg::*;

  localparam int DEPTH = LABEL_MAX + VALUE_MAX;
  localparam int AW    = $clog2(DEPTH);

  logic          busy, in_take;
  logic          mem_we, rd_en;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [7:0]    mem_wdata, rd_data;
  rec_t          rec;

  assign in_ready = !busy;
  assign in_take  = in_valid && in_ready;

  lvlp_parse #(
    .LABEL_MAX(LABEL_MAX),
    .VALUE_MAX(VALUE_MAX),
    .AW       (AW)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .rec      (rec)
  );

  lvlp_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lvlp_emit #(
    .LABEL_MAX(LABEL_MAX),
    .AW       (AW)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec      (rec),
    .rd_data  (rd_data),
    .out_ready(out_ready),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

// ===== design/lvlp_mem.sv =====
// lvlp_mem: record byte store, label entries first, then value entries.
// One write port, one read port with registered data. Uses lvlp_pkg.
`default_nettype none
module lvlp_mem #(
  parameter int DEPTH = lvlp_pkg::LABEL_MAX_DEF + lvlp_pkg::VALUE_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);
  import lvlp_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/lvlp_parse.sv =====
// lvlp_parse: per-byte line parser, gap timeout, frame/publish control, config registers.
// Writes record bytes into lvlp_mem and hands finished records to lvlp_emit. Uses lvlp_pkg.
`default_nettype none
module lvlp_parse #(
  parameter int LABEL_MAX = lvlp_pkg::LABEL_MAX_DEF,
  parameter int VALUE_MAX = lvlp_pkg::VALUE_MAX_DEF,
  parameter int AW        = $clog2(LABEL_MAX + VALUE_MAX)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_take,
  input  wire lvlp_pkg::in_item_t              in_item,
  input  wire logic                            cfg_we,
  input  wire logic [lvlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lvlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                                 mem_we,
  output logic      [AW-1:0]                   mem_waddr,
  output logic      [7:0]                      mem_wdata,
  output lvlp_pkg::rec_t                       rec
);
  import lvlp_pkg::*;

  phase_t              phase_r, phase_nxt, eff_phase;
  logic [CNT_W-1:0]    lc_r, lc_nxt, lc_b;
  logic [CNT_W-1:0]    vc_r, vc_nxt, vc_b;
  logic                ov_r, ov_nxt, ov_b;
  logic                endm_r, endm_nxt, endm_b;
  logic                run_r, run_nxt, run_b;
  logic [TIME_W-1:0]   last_rx_r, last_rx_nxt;
  logic [TIME_W-1:0]   last_pub_r, last_pub_nxt;
  logic                pub_en_r, pub_en_nxt;
  logic [GAP_W-1:0]    gap_r;
  logic [TIME_W-1:0]   intv_r;
  logic                start_nxt;

  logic [7:0]          c;
  logic [TIME_W-1:0]   now;
  logic                is_eol, gap_hit, pub_ok, idle_eol;

  assign c        = in_item.rx_char;
  assign now      = in_item.now_ms;
  assign is_eol   = (c == CH_CR) || (c == CH_LF);
  assign gap_hit  = (now - last_rx_r) >= {{(TIME_W-GAP_W){1'b0}}, gap_r};
  assign pub_ok   = (now - last_pub_r) >= intv_r;
  assign eff_phase = (phase_r != PH_IDLE && gap_hit) ? PH_IDLE : phase_r;
  assign idle_eol = (eff_phase == PH_IDLE) && is_eol;

  // a fresh line starts from cleared counters
  assign lc_b   = (eff_phase == PH_IDLE) ? '0   : lc_r;
  assign vc_b   = (eff_phase == PH_IDLE) ? '0   : vc_r;
  assign ov_b   = (eff_phase == PH_IDLE) ? 1'b0 : ov_r;
  assign endm_b = (eff_phase == PH_IDLE) ? 1'b0 : endm_r;
  assign run_b  = (eff_phase == PH_IDLE) ? 1'b1 : run_r;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (in_take) begin
      unique case (eff_phase) inside
        PH_IDLE, PH_LABEL: begin
          if (idle_eol)           phase_nxt = PH_IDLE;
          else if (c == CH_COLON) phase_nxt = PH_HEX;
          else if (c == CH_TAB)   phase_nxt = PH_VALUE;
          else                    phase_nxt = PH_LABEL;
        end
        PH_VALUE: begin
          phase_nxt = (endm_r || is_eol) ? PH_IDLE : PH_VALUE;
        end
        PH_HEX: begin
          phase_nxt = is_eol ? PH_IDLE : PH_HEX;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    lc_nxt       = lc_r;
    vc_nxt       = vc_r;
    ov_nxt       = ov_r;
    endm_nxt     = endm_r;
    run_nxt      = run_r;
    last_rx_nxt  = last_rx_r;
    last_pub_nxt = last_pub_r;
    pub_en_nxt   = pub_en_r;
    start_nxt    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = AW'(lc_b);
    mem_wdata    = c;
    if (in_take) begin
      last_rx_nxt = now;
      unique case (eff_phase) inside
        PH_IDLE, PH_LABEL: begin
          if (!idle_eol) begin
            lc_nxt   = lc_b;
            vc_nxt   = vc_b;
            ov_nxt   = ov_b;
            endm_nxt = endm_b;
            run_nxt  = run_b;
            if (c == CH_COLON) begin
              // hex frame, nothing stored
            end else if (c == CH_TAB) begin
              endm_nxt = run_b && !ov_b && (lc_b == CNT_W'(END_WORD_LEN));
            end else if (lc_b < CNT_W'(LABEL_MAX)) begin
              mem_we  = 1'b1;
              lc_nxt  = lc_b + 1'b1;
              run_nxt = run_b && (lc_b < CNT_W'(END_WORD_LEN)) &&
                        (c == end_word_char(lc_b[2:0]));
            end else begin
              ov_nxt = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          mem_waddr = AW'(LABEL_MAX) + AW'(vc_r);
          if (endm_r) begin
            pub_en_nxt = pub_ok;
            if (pub_ok) last_pub_nxt = now;
          end else if (is_eol) begin
            start_nxt = pub_en_r;
          end else if (vc_r < CNT_W'(VALUE_MAX)) begin
            mem_we = 1'b1;
            vc_nxt = vc_r + 1'b1;
          end else begin
            ov_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rec.start       = start_nxt;
  assign rec.label_count = lc_r;
  assign rec.value_count = vc_r;
  assign rec.overflow    = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      lc_r       <= '0;
      vc_r       <= '0;
      ov_r       <= 1'b0;
      endm_r     <= 1'b0;
      run_r      <= 1'b1;
      last_rx_r  <= '0;
      last_pub_r <= '0;
      pub_en_r   <= 1'b1;
      gap_r      <= GAP_RESET;
      intv_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      lc_r       <= lc_nxt;
      vc_r       <= vc_nxt;
      ov_r       <= ov_nxt;
      endm_r     <= endm_nxt;
      run_r      <= run_nxt;
      last_rx_r  <= last_rx_nxt;
      last_pub_r <= last_pub_nxt;
      pub_en_r   <= pub_en_nxt;
      if (cfg_we && cfg_index == CFG_GAP_TIMEOUT)  gap_r  <= cfg_wdata[GAP_W-1:0];
      if (cfg_we && cfg_index == CFG_PUB_INTERVAL) intv_r <= cfg_wdata[TIME_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/lvlp_emit.sv =====
// lvlp_emit: reads a finished record out of lvlp_mem, one byte per item.
// The memory's registered read data is the output register. Uses lvlp_pkg.
`default_nettype none
module lvlp_emit #(
  parameter int LABEL_MAX = lvlp_pkg::LABEL_MAX_DEF,
  parameter int AW        = $clog2(LABEL_MAX + lvlp_pkg::VALUE_MAX_DEF)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lvlp_pkg::rec_t rec,
  input  wire logic [7:0]    rd_data,
  input  wire logic          out_ready,
  output logic               busy,
  output logic               rd_en,
  output logic      [AW-1:0] rd_addr,
  output logic               out_valid,
  output lvlp_pkg::out_item_t out_item
);
  import lvlp_pkg::*;

  logic             active_r, active_nxt;
  logic [TOT_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic             cv_r, cv_nxt, iv_r, iv_nxt, tr_r, tr_nxt, last_r, last_nxt;
  logic [TOT_W-1:0] total, idx_inc, lc_w;
  logic             issue, empty, in_lbl, fin;

  assign lc_w    = TOT_W'(rec.label_count);
  assign total   = lc_w + TOT_W'(rec.value_count);
  assign empty   = (total == '0);
  assign idx_inc = idx_r + 1'b1;
  assign fin     = empty || (idx_inc == total);
  assign issue   = active_r && (!ov_r || out_ready);
  assign in_lbl  = idx_r < lc_w;

  assign rd_en   = issue && !empty;
  assign rd_addr = in_lbl ? AW'(idx_r) : AW'(LABEL_MAX) + AW'(idx_r - lc_w);

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    ov_nxt     = ov_r;
    cv_nxt     = cv_r;
    iv_nxt     = iv_r;
    tr_nxt     = tr_r;
    last_nxt   = last_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (rec.start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (issue) begin
      ov_nxt   = 1'b1;
      idx_nxt  = idx_inc;
      cv_nxt   = !empty;
      iv_nxt   = !empty && !in_lbl;
      tr_nxt   = rec.overflow;
      last_nxt = fin;
      if (fin) active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cv_r   <= cv_nxt;
    iv_r   <= iv_nxt;
    tr_r   <= tr_nxt;
    last_r <= last_nxt;
  end

  assign busy                 = active_r;
  assign out_valid            = ov_r;
  assign out_item.record_char = cv_r ? rd_data : 8'h00;
  assign out_item.char_valid  = cv_r;
  assign out_item.in_value    = iv_r;
  assign out_item.truncated   = tr_r;
  assign out_item.last        = last_r;

endmodule
`default_nettype wire

// ===== design/lvlp_chk.sv =====
// lvlp_chk: port-level checks for label_value_line_parser, bound to the top level.
// Uses lvlp_pkg types.
`default_nettype none
module lvlp_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lvlp_pkg::out_item_t out_item
);
  import lvlp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.char_valid |->
      out_item.record_char == 8'h00 && out_item.last && !out_item.in_value)
    else $error("malformed empty record item");

  a_busy_mid_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> !in_ready)
    else $error("input taken in the middle of a record");

  a_record_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item.last |=> out_valid)
    else $error("gap inside a record readout");

endmodule

bind label_value_line_parser lvlp_chk u_lvlp_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
`default_nettype wire
